// ===== hdl/mics_pkg.sv =====
// mics_pkg: shared types, codes and helpers for the mips integer subset core
// used by mics_muldiv, mips_integer_subset_core_top and the testbench; depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package mics_pkg;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_FETCH,
		S_RS,
		S_RT,
		S_EXEC,
		S_MEM,
		S_MD,
		S_RDREG,
		S_DONE
	} state_t;

	// request commands
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_EXEC = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_BADOP = 3'd1;
	localparam logic [2:0] ST_ALIGN = 3'd2;
	localparam logic [2:0] ST_RANGE = 3'd3;
	localparam logic [2:0] ST_DIV0  = 3'd4;
	localparam logic [2:0] ST_HALT  = 3'd5;

	// primary opcodes
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_J       = 6'h02;
	localparam logic [5:0] OP_JAL     = 6'h03;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BLEZ    = 6'h06;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_ADDIU   = 6'h09;
	localparam logic [5:0] OP_SLTI    = 6'h0A;
	localparam logic [5:0] OP_SLTIU   = 6'h0B;
	localparam logic [5:0] OP_ANDI    = 6'h0C;
	localparam logic [5:0] OP_ORI     = 6'h0D;
	localparam logic [5:0] OP_XORI    = 6'h0E;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_LB      = 6'h20;
	localparam logic [5:0] OP_LH      = 6'h21;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_LBU     = 6'h24;
	localparam logic [5:0] OP_LHU     = 6'h25;
	localparam logic [5:0] OP_SB      = 6'h28;
	localparam logic [5:0] OP_SH      = 6'h29;
	localparam logic [5:0] OP_SW      = 6'h2B;

	// special function codes
	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_SRA     = 6'h03;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_MFHI    = 6'h10;
	localparam logic [5:0] FN_MFLO    = 6'h12;
	localparam logic [5:0] FN_MULT    = 6'h18;
	localparam logic [5:0] FN_DIV     = 6'h1A;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_XOR     = 6'h26;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2A;
	localparam logic [5:0] FN_SLTU    = 6'h2B;

	// syscall services and fixed registers
	localparam logic [31:0] SYS_PRINT = 32'd1;
	localparam logic [31:0] SYS_EXIT  = 32'd10;
	localparam logic [4:0]  REG_V0    = 5'd2;
	localparam logic [4:0]  REG_A0    = 5'd4;
	localparam logic [4:0]  REG_GP    = 5'd28;
	localparam logic [4:0]  REG_SP    = 5'd29;
	localparam logic [4:0]  REG_RA    = 5'd31;
	localparam logic [31:0] GP_INIT   = 32'h0000_1800;
	localparam logic [31:0] SP_INIT   = 32'h0000_3ffc;

	// multiply/divide unit request and response
	typedef struct packed {
		logic        start;
		logic        is_div;
		logic [31:0] a;
		logic [31:0] b;
	} md_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] hi;
		logic [31:0] lo;
	} md_rsp_t;

	// value of a register that was never written
	function automatic logic [31:0] rf_reset_val(input logic [4:0] idx);
		logic [31:0] v;
		v = 32'd0;
		if (idx == REG_GP)
			v = GP_INIT;
		else if (idx == REG_SP)
			v = SP_INIT;
		return v;
	endfunction

	// syscall instruction reads v0 and a0 instead of rs and rt
	function automatic logic is_syscall(input logic [31:0] ins);
		return (ins[31:26] == OP_SPECIAL) && (ins[5:0] == FN_SYSCALL);
	endfunction

endpackage
`default_nettype wire

// ===== hdl/mics_ram.sv =====
// mics_ram: generic single write port, single read port ram with registered read
// standalone, no dependencies
`timescale 1ns / 1ps
`default_nettype none
module mics_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/mics_muldiv.sv =====
// mics_muldiv: iterative signed multiply and divide, one bit per cycle
// depends on mics_pkg
`timescale 1ns / 1ps
`default_nettype none
module mics_muldiv (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mics_pkg::md_req_t req,
	output mics_pkg::md_rsp_t      rsp
);
	import mics_pkg::*;

	logic        busy_q;
	logic        fin_q;
	logic        done_q;
	logic        is_div_q;
	logic        neg_lo_q;
	logic        neg_hi_q;
	logic [4:0]  cnt_q;
	logic [31:0] op_q;
	logic [63:0] p_q;
	logic [31:0] hi_q;
	logic [31:0] lo_q;

	logic        na;
	logic        nb;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [32:0] mul_sum;
	logic [32:0] r_sh;
	logic [32:0] diff;
	logic [63:0] prod_neg;

	// operand magnitudes and one step of either algorithm
	always_comb begin
		na       = req.a[31];
		nb       = req.b[31];
		ma       = na ? (32'd0 - req.a) : req.a;
		mb       = nb ? (32'd0 - req.b) : req.b;
		mul_sum  = {1'b0, p_q[63:32]} + (p_q[0] ? {1'b0, op_q} : 33'd0);
		r_sh     = {p_q[63:32], p_q[31]};
		diff     = r_sh - {1'b0, op_q};
		prod_neg = 64'd0 - p_q;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// datapath: shift-add multiply, restoring divide
	always_ff @(posedge clk) begin
		if (req.start) begin
			is_div_q <= req.is_div;
			neg_lo_q <= na ^ nb;
			neg_hi_q <= req.is_div ? na : (na ^ nb);
			op_q     <= req.is_div ? mb : ma;
			p_q      <= {32'd0, req.is_div ? ma : mb};
		end else if (busy_q) begin
			if (!is_div_q)
				p_q <= {mul_sum, p_q[31:1]};
			else if (!diff[32])
				p_q <= {diff[31:0], p_q[30:0], 1'b1};
			else
				p_q <= {r_sh[31:0], p_q[30:0], 1'b0};
		end
		if (fin_q) begin
			if (!is_div_q) begin
				hi_q <= neg_lo_q ? prod_neg[63:32] : p_q[63:32];
				lo_q <= neg_lo_q ? prod_neg[31:0] : p_q[31:0];
			end else begin
				hi_q <= neg_hi_q ? (32'd0 - p_q[63:32]) : p_q[63:32];
				lo_q <= neg_lo_q ? (32'd0 - p_q[31:0]) : p_q[31:0];
			end
		end
	end

	assign rsp = '{done: done_q, hi: hi_q, lo: lo_q};

endmodule
`default_nettype wire

// ===== hdl/mips_integer_subset_core_top.sv =====
// mips_integer_subset_core_top: multicycle mips32 integer subset core
// depends on mics_pkg, mics_ram, mics_muldiv
//
// channel   direction  handshake               payload
// request   in         req_valid / req_stall   cmd, addr, data
// result    out        res_valid / res_stall   pc_after, instr, status, halted,
//                                              print_valid, print_value, read_data
//
// one request at a time; the result register waits until taken, then a new
// request is accepted. instructions read rs and rt in turn through the single
// read port of the register file ram; mult and div wait on the bit-serial
// multiply/divide unit, and loads and sub-word stores take an extra memory step.
// reset clears pc, hi, lo, halt and the register valid bits; memory contents are
// kept. res_stall holds the result and req_stall.
`timescale 1ns / 1ps
`default_nettype none
module mips_integer_subset_core_top #(
	parameter int MEM_WORDS = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic [11:0]        addr,
	input  wire logic [31:0]        data,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [31:0]             pc_after,
	output logic [31:0]             instr,
	output logic [2:0]              status,
	output logic                    halted,
	output logic                    print_valid,
	output logic signed [31:0]      print_value,
	output logic [31:0]             read_data
);
	import mics_pkg::*;

	localparam int          AW        = $clog2(MEM_WORDS);
	localparam logic [31:0] MemWordsW = 32'(MEM_WORDS);

	state_t state_q, state_d;

	logic [1:0]  cmd_q;
	logic [11:0] addr_q;
	logic [31:0] data_q;
	logic [31:0] pc_q;
	logic        halt_q;
	logic [31:0] hi_q;
	logic [31:0] lo_q;
	logic [31:0] rf_valid_q;
	logic [4:0]  rf_ridx_q;
	logic [31:0] instr_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] ea_q;
	logic [2:0]  status_q;
	logic        print_valid_q;
	logic [31:0] print_value_q;
	logic [31:0] read_data_q;

	// memory and register file ports
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_wdata, mem_rdata;
	logic          rf_we, rf_re;
	logic [4:0]    rf_waddr, rf_raddr;
	logic [31:0]   rf_wdata, rf_rdata, rf_val;

	md_req_t md_req;
	md_rsp_t md_rsp;

	mics_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
	);

	mics_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.re(rf_re), .raddr(rf_raddr), .rdata(rf_rdata)
	);

	mics_muldiv u_md (.clk(clk), .arst_n(arst_n), .req(md_req), .rsp(md_rsp));

	// never-written registers read as their reset value
	assign rf_val = rf_valid_q[rf_ridx_q] ? rf_rdata : rf_reset_val(rf_ridx_q);

	// checks on the latched request
	logic load_ok, pc_bad_align, pc_bad_range;
	assign load_ok      = {20'd0, addr_q} < MemWordsW;
	assign pc_bad_align = pc_q[1:0] != 2'b00;
	assign pc_bad_range = {2'b00, pc_q[31:2]} >= MemWordsW;

	// instruction decode and execute
	logic [5:0]  op, fn;
	logic [4:0]  rt, rd, sh;
	logic [15:0] imm;
	logic [31:0] simm, ea, npc_seq, brt, jtgt;
	logic        ea_range;
	logic [2:0]  ex_status;
	logic [31:0] ex_npc, ex_wdata;
	logic [4:0]  ex_widx;
	logic        ex_wen, ex_md, ex_md_div, ex_mem_rd, ex_mem_wr, ex_print, ex_halt;

	always_comb begin
		op       = instr_q[31:26];
		rt       = instr_q[20:16];
		rd       = instr_q[15:11];
		sh       = instr_q[10:6];
		fn       = instr_q[5:0];
		imm      = instr_q[15:0];
		simm     = {{16{imm[15]}}, imm};
		ea       = a_q + simm;
		ea_range = {2'b00, ea[31:2]} >= MemWordsW;
		npc_seq  = pc_q + 32'd4;
		brt      = npc_seq + {simm[29:0], 2'b00};
		jtgt     = {npc_seq[31:28], instr_q[25:0], 2'b00};

		ex_status = ST_OK;
		ex_npc    = npc_seq;
		ex_wen    = 1'b0;
		ex_widx   = rt;
		ex_wdata  = 32'd0;
		ex_md     = 1'b0;
		ex_md_div = 1'b0;
		ex_mem_rd = 1'b0;
		ex_mem_wr = 1'b0;
		ex_print  = 1'b0;
		ex_halt   = 1'b0;

		unique case (op)
			OP_SPECIAL: begin
				ex_widx = rd;
				unique case (fn)
					FN_ADD, FN_ADDU: begin
						ex_wen = 1'b1; ex_wdata = a_q + b_q;
					end
					FN_SUB: begin
						ex_wen = 1'b1; ex_wdata = a_q - b_q;
					end
					FN_AND: begin
						ex_wen = 1'b1; ex_wdata = a_q & b_q;
					end
					FN_OR: begin
						ex_wen = 1'b1; ex_wdata = a_q | b_q;
					end
					FN_XOR: begin
						ex_wen = 1'b1; ex_wdata = a_q ^ b_q;
					end
					FN_NOR: begin
						ex_wen = 1'b1; ex_wdata = ~(a_q | b_q);
					end
					FN_SLT: begin
						ex_wen = 1'b1; ex_wdata = {31'd0, $signed(a_q) < $signed(b_q)};
					end
					FN_SLTU: begin
						ex_wen = 1'b1; ex_wdata = {31'd0, a_q < b_q};
					end
					FN_SLL: begin
						ex_wen = 1'b1; ex_wdata = b_q << sh;
					end
					FN_SRL: begin
						ex_wen = 1'b1; ex_wdata = b_q >> sh;
					end
					FN_SRA: begin
						ex_wen = 1'b1; ex_wdata = 32'($signed(b_q) >>> sh);
					end
					FN_JR: begin
						ex_npc = a_q;
					end
					FN_MFHI: begin
						ex_wen = 1'b1; ex_wdata = hi_q;
					end
					FN_MFLO: begin
						ex_wen = 1'b1; ex_wdata = lo_q;
					end
					FN_MULT: begin
						ex_md = 1'b1;
					end
					FN_DIV: begin
						if (b_q == 32'd0)
							ex_status = ST_DIV0;
						else begin
							ex_md = 1'b1; ex_md_div = 1'b1;
						end
					end
					FN_SYSCALL: begin
						// a_q holds v0, b_q holds a0
						if (a_q == SYS_PRINT)
							ex_print = 1'b1;
						else if (a_q == SYS_EXIT)
							ex_halt = 1'b1;
					end
					default: ex_status = ST_BADOP;
				endcase
			end
			OP_J: ex_npc = jtgt;
			OP_JAL: begin
				ex_npc = jtgt; ex_wen = 1'b1; ex_widx = REG_RA; ex_wdata = npc_seq;
			end
			OP_BEQ: if (a_q == b_q) ex_npc = brt;
			OP_BNE: if (a_q != b_q) ex_npc = brt;
			OP_BLEZ: if (a_q == 32'd0 || a_q[31]) ex_npc = brt;
			OP_BGTZ: if (a_q != 32'd0 && !a_q[31]) ex_npc = brt;
			OP_ADDI, OP_ADDIU: begin
				ex_wen = 1'b1; ex_wdata = a_q + simm;
			end
			OP_SLTI: begin
				ex_wen = 1'b1; ex_wdata = {31'd0, $signed(a_q) < $signed(simm)};
			end
			OP_SLTIU: begin
				ex_wen = 1'b1; ex_wdata = {31'd0, a_q < simm};
			end
			OP_ANDI: begin
				ex_wen = 1'b1; ex_wdata = a_q & {16'd0, imm};
			end
			OP_ORI: begin
				ex_wen = 1'b1; ex_wdata = a_q | {16'd0, imm};
			end
			OP_XORI: begin
				ex_wen = 1'b1; ex_wdata = a_q ^ {16'd0, imm};
			end
			OP_LUI: begin
				ex_wen = 1'b1; ex_wdata = {imm, 16'd0};
			end
			OP_LB, OP_LBU, OP_SB: begin
				if (ea_range)
					ex_status = ST_RANGE;
				else
					ex_mem_rd = 1'b1;
			end
			OP_LH, OP_LHU, OP_SH: begin
				if (ea[0])
					ex_status = ST_ALIGN;
				else if (ea_range)
					ex_status = ST_RANGE;
				else
					ex_mem_rd = 1'b1;
			end
			OP_LW, OP_SW: begin
				if (ea[1:0] != 2'b00)
					ex_status = ST_ALIGN;
				else if (ea_range)
					ex_status = ST_RANGE;
				else if (op == OP_SW)
					ex_mem_wr = 1'b1;
				else
					ex_mem_rd = 1'b1;
			end
			default: ex_status = ST_BADOP;
		endcase

		if (ex_widx == 5'd0)
			ex_wen = 1'b0;
	end

	// load extraction and sub-word store merge
	logic [31:0] lane_w, ld_val, st_val;
	always_comb begin
		lane_w = mem_rdata >> {ea_q[1:0], 3'b000};
		unique case (instr_q[31:26])
			OP_LB:   ld_val = {{24{lane_w[7]}}, lane_w[7:0]};
			OP_LBU:  ld_val = {24'd0, lane_w[7:0]};
			OP_LH:   ld_val = {{16{lane_w[15]}}, lane_w[15:0]};
			OP_LHU:  ld_val = {16'd0, lane_w[15:0]};
			default: ld_val = mem_rdata;
		endcase
		if (instr_q[31:26] == OP_SB)
			st_val = (mem_rdata & ~(32'h0000_00ff << {ea_q[1:0], 3'b000}))
				| ({24'd0, b_q[7:0]} << {ea_q[1:0], 3'b000});
		else
			st_val = (mem_rdata & ~(32'h0000_ffff << {ea_q[1:0], 3'b000}))
				| ({16'd0, b_q[15:0]} << {ea_q[1:0], 3'b000});
	end

	logic is_store_sub;
	assign is_store_sub = (instr_q[31:26] == OP_SB) || (instr_q[31:26] == OP_SH);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req_valid) state_d = S_START;
			S_START: begin
				if (cmd_q == CMD_EXEC && !halt_q && !pc_bad_align && !pc_bad_range)
					state_d = S_FETCH;
				else if (cmd_q == CMD_READ && addr_q < 12'd32)
					state_d = S_RDREG;
				else
					state_d = S_DONE;
			end
			S_FETCH: state_d = S_RS;
			S_RS:    state_d = S_RT;
			S_RT:    state_d = S_EXEC;
			S_EXEC: begin
				if (ex_status != ST_OK)
					state_d = S_DONE;
				else if (ex_md)
					state_d = S_MD;
				else if (ex_mem_rd)
					state_d = S_MEM;
				else
					state_d = S_DONE;
			end
			S_MEM:   state_d = S_DONE;
			S_MD:    if (md_rsp.done) state_d = S_DONE;
			S_RDREG: state_d = S_DONE;
			S_DONE:  if (!res_stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory, register file and unit controls
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ea_q[AW+1:2];
		mem_wdata = st_val;
		mem_re    = 1'b0;
		mem_raddr = pc_q[AW+1:2];
		rf_we     = 1'b0;
		rf_waddr  = ex_widx;
		rf_wdata  = ex_wdata;
		rf_re     = 1'b0;
		rf_raddr  = addr_q[4:0];
		md_req    = '{start: 1'b0, is_div: ex_md_div, a: a_q, b: b_q};
		unique case (state_q)
			S_START: begin
				if (cmd_q == CMD_LOAD && load_ok) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(addr_q);
					mem_wdata = data_q;
				end
				mem_re = cmd_q == CMD_EXEC;
				rf_re  = cmd_q == CMD_READ;
			end
			S_FETCH: begin
				rf_re    = 1'b1;
				rf_raddr = is_syscall(mem_rdata) ? REG_V0 : mem_rdata[25:21];
			end
			S_RS: begin
				rf_re    = 1'b1;
				rf_raddr = is_syscall(instr_q) ? REG_A0 : instr_q[20:16];
			end
			S_EXEC: begin
				mem_re    = ex_mem_rd;
				mem_raddr = ea[AW+1:2];
				mem_we    = ex_mem_wr;
				mem_waddr = ea[AW+1:2];
				mem_wdata = b_q;
				rf_we     = ex_status == ST_OK && ex_wen;
				md_req.start = ex_status == ST_OK && ex_md;
			end
			S_MEM: begin
				mem_we   = is_store_sub;
				rf_we    = !is_store_sub && instr_q[20:16] != 5'd0;
				rf_waddr = instr_q[20:16];
				rf_wdata = ld_val;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pc_q       <= 32'd0;
			halt_q     <= 1'b0;
			hi_q       <= 32'd0;
			lo_q       <= 32'd0;
			rf_valid_q <= 32'd0;
		end else begin
			state_q <= state_d;
			if (rf_we)
				rf_valid_q[rf_waddr] <= 1'b1;
			if (state_q == S_EXEC) begin
				pc_q <= (ex_status == ST_OK) ? ex_npc : npc_seq;
				if (ex_status == ST_OK && ex_halt)
					halt_q <= 1'b1;
			end
			if (state_q == S_MD && md_rsp.done) begin
				hi_q <= md_rsp.hi;
				lo_q <= md_rsp.lo;
			end
		end
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (rf_re)
			rf_ridx_q <= rf_raddr;
		unique case (state_q)
			S_IDLE: begin
				cmd_q  <= cmd;
				addr_q <= addr;
				data_q <= data;
			end
			S_START: begin
				instr_q       <= 32'd0;
				print_valid_q <= 1'b0;
				print_value_q <= 32'd0;
				read_data_q   <= 32'd0;
				unique case (cmd_q)
					CMD_LOAD: status_q <= load_ok ? ST_OK : ST_RANGE;
					CMD_EXEC: begin
						if (halt_q)
							status_q <= ST_HALT;
						else if (pc_bad_align)
							status_q <= ST_ALIGN;
						else if (pc_bad_range)
							status_q <= ST_RANGE;
						else
							status_q <= ST_OK;
					end
					CMD_READ: begin
						status_q <= (addr_q < 12'd34) ? ST_OK : ST_RANGE;
						if (addr_q == 12'd32)
							read_data_q <= hi_q;
						else if (addr_q == 12'd33)
							read_data_q <= lo_q;
					end
					default: status_q <= ST_BADOP;
				endcase
			end
			S_FETCH: instr_q <= mem_rdata;
			S_RS:    a_q <= rf_val;
			S_RT:    b_q <= rf_val;
			S_EXEC: begin
				status_q      <= ex_status;
				ea_q          <= ea;
				print_valid_q <= ex_status == ST_OK && ex_print;
				print_value_q <= (ex_status == ST_OK && ex_print) ? b_q : 32'd0;
			end
			S_RDREG: read_data_q <= rf_val;
			default: ;
		endcase
	end

	// ports
	assign req_stall   = state_q != S_IDLE;
	assign res_valid   = state_q == S_DONE;
	assign pc_after    = pc_q;
	assign instr       = instr_q;
	assign status      = status_q;
	assign halted      = halt_q;
	assign print_valid = print_valid_q;
	assign print_value = print_value_q;
	assign read_data   = read_data_q;

	// register zero is never written
	a_rf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> rf_waddr != 5'd0)
		else $error("write to register zero");

	// halt is sticky
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared");

	// a taken result frees the core for the next request
	a_res_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall) |=> (!res_valid && !req_stall))
		else $error("result not retired");

	// the pc only moves while an instruction executes
	a_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_EXEC) |=> $stable(pc_q))
		else $error("pc changed outside execute");

endmodule
`default_nettype wire

// ===== tb/mics_result_check.sv =====
// mics_result_check: watches the request and result channels of the core, keeps a
// shadow copy of memory, registers, hi, lo, pc and halt, and compares every result
// depends on mics_pkg
`timescale 1ns / 1ps
`default_nettype none
module mics_result_check
	import mics_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	input  wire logic               req_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic [11:0]        addr,
	input  wire logic [31:0]        data,
	input  wire logic               res_valid,
	input  wire logic               res_stall,
	input  wire logic [31:0]        pc_after,
	input  wire logic [31:0]        instr,
	input  wire logic [2:0]         status,
	input  wire logic               halted,
	input  wire logic               print_valid,
	input  wire logic signed [31:0] print_value,
	input  wire logic [31:0]        read_data,
	output int                      fail_count,
	output int                      pending,
	output logic [31:0]             cur_pc
);

	localparam int MEM_WORDS = 4096;

	typedef struct packed {
		logic [31:0] pc_after;
		logic [31:0] instr;
		logic [2:0]  status;
		logic        halted;
		logic        print_valid;
		logic [31:0] print_value;
		logic [31:0] read_data;
	} core_result_t;

	// shadow architectural state
	logic [31:0] mem_img [0:MEM_WORDS-1];
	logic [31:0] gpr [0:31];
	logic [31:0] hi_q, lo_q, pc_q;
	logic        halt_q;

	core_result_t expected_results[$];

	assign pending = expected_results.size();
	assign cur_pc = pc_q;

	initial begin
		fail_count = 0;
		for (int i = 0; i < MEM_WORDS; i++)
			mem_img[i] = 32'd0;
		for (int i = 0; i < 32; i++)
			gpr[i] = 32'd0;
		gpr[REG_GP] = GP_INIT;
		gpr[REG_SP] = SP_INIT;
		hi_q = 32'd0;
		lo_q = 32'd0;
		pc_q = 32'd0;
		halt_q = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s got %h expected %h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic put_gpr(input logic [4:0] n, input logic [31:0] v);
		if (n != 5'd0)
			gpr[n] = v;
	endtask

	// alignment first, then range
	function automatic logic [2:0] data_fault(input logic [31:0] ea, input logic [1:0] amask);
		if ((ea[1:0] & amask) != 2'b00)
			return ST_ALIGN;
		if ((ea >> 2) >= MEM_WORDS)
			return ST_RANGE;
		return ST_OK;
	endfunction

	// one instruction; faults leave the state untouched
	task automatic step_instr(input logic [31:0] ins, inout logic [31:0] npc,
			output logic [2:0] st, output logic pv, output logic [31:0] pval);
		logic [5:0]  op, fn;
		logic [4:0]  rs, rt, rd, sh, lane;
		logic [31:0] imm, simm, a, b, ea, brt, w, ma, mb, q, r;
		logic [63:0] prod;
		op = ins[31:26];
		rs = ins[25:21];
		rt = ins[20:16];
		rd = ins[15:11];
		sh = ins[10:6];
		fn = ins[5:0];
		imm = {16'd0, ins[15:0]};
		simm = {{16{ins[15]}}, ins[15:0]};
		a = gpr[rs];
		b = gpr[rt];
		ea = a + simm;
		lane = {ea[1:0], 3'b000};
		brt = npc + (simm << 2);
		st = ST_OK;
		pv = 1'b0;
		pval = 32'd0;
		case (op)
			OP_SPECIAL: begin
				case (fn)
					FN_ADD, FN_ADDU: put_gpr(rd, a + b);
					FN_SUB: put_gpr(rd, a - b);
					FN_AND: put_gpr(rd, a & b);
					FN_OR: put_gpr(rd, a | b);
					FN_XOR: put_gpr(rd, a ^ b);
					FN_NOR: put_gpr(rd, ~(a | b));
					FN_SLT: put_gpr(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
					FN_SLTU: put_gpr(rd, (a < b) ? 32'd1 : 32'd0);
					FN_SLL: put_gpr(rd, b << sh);
					FN_SRL: put_gpr(rd, b >> sh);
					FN_SRA: put_gpr(rd, $signed(b) >>> sh);
					FN_JR: npc = a;
					FN_MFHI: put_gpr(rd, hi_q);
					FN_MFLO: put_gpr(rd, lo_q);
					FN_MULT: begin
						prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
						lo_q = prod[31:0];
						hi_q = prod[63:32];
					end
					FN_DIV: begin
						if (b == 32'd0) begin
							st = ST_DIV0;
						end else begin
							ma = a[31] ? -a : a;
							mb = b[31] ? -b : b;
							q = ma / mb;
							r = ma % mb;
							lo_q = (a[31] != b[31]) ? -q : q;
							hi_q = a[31] ? -r : r;
						end
					end
					FN_SYSCALL: begin
						if (gpr[REG_V0] == SYS_PRINT) begin
							pv = 1'b1;
							pval = gpr[REG_A0];
						end else if (gpr[REG_V0] == SYS_EXIT) begin
							halt_q = 1'b1;
						end
					end
					default: st = ST_BADOP;
				endcase
			end
			OP_J: npc = {npc[31:28], ins[25:0], 2'b00};
			OP_JAL: begin
				put_gpr(REG_RA, npc);
				npc = {npc[31:28], ins[25:0], 2'b00};
			end
			OP_BEQ: if (a == b) npc = brt;
			OP_BNE: if (a != b) npc = brt;
			OP_BLEZ: if (a == 32'd0 || a[31]) npc = brt;
			OP_BGTZ: if (a != 32'd0 && !a[31]) npc = brt;
			OP_ADDI, OP_ADDIU: put_gpr(rt, a + simm);
			OP_SLTI: put_gpr(rt, ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0);
			OP_SLTIU: put_gpr(rt, (a < simm) ? 32'd1 : 32'd0);
			OP_ANDI: put_gpr(rt, a & imm);
			OP_ORI: put_gpr(rt, a | imm);
			OP_XORI: put_gpr(rt, a ^ imm);
			OP_LUI: put_gpr(rt, {ins[15:0], 16'd0});
			OP_LB, OP_LBU: begin
				st = data_fault(ea, 2'b00);
				if (st == ST_OK) begin
					w = (mem_img[ea[13:2]] >> lane) & 32'hff;
					put_gpr(rt, (op == OP_LB) ? {{24{w[7]}}, w[7:0]} : w);
				end
			end
			OP_LH, OP_LHU: begin
				st = data_fault(ea, 2'b01);
				if (st == ST_OK) begin
					w = (mem_img[ea[13:2]] >> lane) & 32'hffff;
					put_gpr(rt, (op == OP_LH) ? {{16{w[15]}}, w[15:0]} : w);
				end
			end
			OP_LW: begin
				st = data_fault(ea, 2'b11);
				if (st == ST_OK)
					put_gpr(rt, mem_img[ea[13:2]]);
			end
			OP_SB: begin
				st = data_fault(ea, 2'b00);
				if (st == ST_OK)
					mem_img[ea[13:2]] = (mem_img[ea[13:2]] & ~(32'hff << lane))
						| ((b & 32'hff) << lane);
			end
			OP_SH: begin
				st = data_fault(ea, 2'b01);
				if (st == ST_OK)
					mem_img[ea[13:2]] = (mem_img[ea[13:2]] & ~(32'hffff << lane))
						| ((b & 32'hffff) << lane);
			end
			OP_SW: begin
				st = data_fault(ea, 2'b11);
				if (st == ST_OK)
					mem_img[ea[13:2]] = b;
			end
			default: st = ST_BADOP;
		endcase
	endtask

	// one request against the shadow state
	task automatic predict_result(input logic [1:0] c, input logic [11:0] a12,
			input logic [31:0] d, output core_result_t e);
		logic [31:0] npc, ins, pval;
		logic [2:0]  st;
		logic        pv;
		e = '0;
		e.status = ST_OK;
		case (c)
			CMD_LOAD: begin
				if (a12 < MEM_WORDS)
					mem_img[a12] = d;
				else
					e.status = ST_RANGE;
			end
			CMD_EXEC: begin
				if (halt_q) begin
					e.status = ST_HALT;
				end else if (pc_q[1:0] != 2'b00) begin
					e.status = ST_ALIGN;
				end else if ((pc_q >> 2) >= MEM_WORDS) begin
					e.status = ST_RANGE;
				end else begin
					npc = pc_q + 32'd4;
					ins = mem_img[pc_q[13:2]];
					step_instr(ins, npc, st, pv, pval);
					e.instr = ins;
					e.status = st;
					e.print_valid = pv;
					e.print_value = pval;
					pc_q = (st == ST_OK) ? npc : pc_q + 32'd4;
				end
			end
			CMD_READ: begin
				if (a12 < 12'd32)
					e.read_data = gpr[a12[4:0]];
				else if (a12 == 12'd32)
					e.read_data = hi_q;
				else if (a12 == 12'd33)
					e.read_data = lo_q;
				else
					e.status = ST_RANGE;
			end
			default: e.status = ST_BADOP;
		endcase
		e.pc_after = pc_q;
		e.halted = halt_q;
	endtask

	// compare taken results, then record new requests
	always @(posedge clk) begin
		core_result_t e;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with no request outstanding", $time);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					if (pc_after !== e.pc_after)
						report_mismatch("pc_after", pc_after, e.pc_after);
					if (instr !== e.instr)
						report_mismatch("instr", instr, e.instr);
					if (status !== e.status)
						report_mismatch("status", status, e.status);
					if (halted !== e.halted)
						report_mismatch("halted", halted, e.halted);
					if (print_valid !== e.print_valid)
						report_mismatch("print_valid", print_valid, e.print_valid);
					if (print_value !== e.print_value)
						report_mismatch("print_value", print_value, e.print_value);
					if (read_data !== e.read_data)
						report_mismatch("read_data", read_data, e.read_data);
				end
			end
			if (req_valid && !req_stall) begin
				predict_result(cmd, addr, data, e);
				expected_results.push_back(e);
			end
		end
	end

endmodule
`default_nettype wire

// ===== tb/mips_integer_subset_core_top_test.sv =====
// mips_integer_subset_core_top_test: preloads memory, runs a directed program and
// random code blocks through the core with bursty requests and result stalls
// depends on mics_pkg, mips_integer_subset_core_top and mics_result_check
`timescale 1ns / 1ps
`default_nettype none
module mips_integer_subset_core_top_test;
	import mics_pkg::*;

	localparam int CODE_TOP = 3071;   // last word used for code; data lives above
	localparam int RANDOM_ITEMS = 2000;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	logic [1:0]         cmd;
	logic [11:0]        addr;
	logic [31:0]        data;
	logic               res_valid;
	logic               res_stall;
	logic [31:0]        pc_after;
	logic [31:0]        instr;
	logic [2:0]         status;
	logic               halted;
	logic               print_valid;
	logic signed [31:0] print_value;
	logic [31:0]        read_data;
	int                 fail_count;
	int                 pending;
	logic [31:0]        cur_pc;

	int          item_count;
	int          burst_left;
	bit          hold_now;
	logic [31:0] code[$];

	mips_integer_subset_core_top dut (.*);

	mics_result_check checker_i (.*);

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// instruction encoders
	function automatic logic [31:0] enc_r(input logic [4:0] rs, input logic [4:0] rt,
			input logic [4:0] rd, input logic [4:0] sh, input logic [5:0] fn);
		return {OP_SPECIAL, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs,
			input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	// any register but v0, so no stray exit request
	function automatic logic [4:0] pick_dest();
		int r;
		r = $urandom_range(0, 30);
		if (r >= REG_V0)
			r++;
		return r[4:0];
	endfunction

	// random instruction that keeps control flow inside the code area
	function automatic logic [31:0] rand_instr(input int widx);
		logic [5:0]  alu_fn[9] = '{FN_ADD, FN_ADDU, FN_SUB, FN_AND, FN_OR, FN_XOR,
			FN_NOR, FN_SLT, FN_SLTU};
		logic [5:0]  sh_fn[3] = '{FN_SLL, FN_SRL, FN_SRA};
		logic [5:0]  imm_op[8] = '{OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI,
			OP_ORI, OP_XORI, OP_LUI};
		logic [5:0]  md_fn[4] = '{FN_MULT, FN_DIV, FN_MFHI, FN_MFLO};
		logic [5:0]  ld_op[5] = '{OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU};
		logic [5:0]  st_op[3] = '{OP_SB, OP_SH, OP_SW};
		logic [5:0]  br_op[4] = '{OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ};
		logic [5:0]  bad_op[5] = '{6'h01, 6'h10, 6'h1f, 6'h22, 6'h3f};
		logic [5:0]  bad_fn[4] = '{6'h01, 6'h05, 6'h19, 6'h3f};
		logic [4:0]  rs, rt;
		logic [15:0] imm;
		int          t;
		rs = $urandom_range(0, 31);
		rt = $urandom_range(0, 31);
		imm = $urandom;
		case ($urandom_range(0, 14))
			0, 1, 2: return enc_r(rs, rt, pick_dest(), 5'd0, alu_fn[$urandom_range(0, 8)]);
			3: return enc_r(rs, rt, pick_dest(), $urandom, sh_fn[$urandom_range(0, 2)]);
			4, 5: return enc_i(imm_op[$urandom_range(0, 7)], rs, pick_dest(), imm);
			6: begin
				t = $urandom_range(0, 3);
				if (t >= 2)
					return enc_r(5'd0, 5'd0, pick_dest(), 5'd0, md_fn[t]);
				return enc_r(rs, rt, 5'd0, 5'd0, md_fn[t]);
			end
			7, 8: begin
				// half the time an absolute address inside memory
				if ($urandom_range(0, 1))
					rs = 5'd0;
				return enc_i(ld_op[$urandom_range(0, 4)], rs, pick_dest(),
					$urandom_range(0, 16'h3fff));
			end
			9, 10: begin
				// stores only hit the data area, or fault
				if ($urandom_range(0, 9) == 0)
					imm = $urandom_range(16'h4000, 16'h7fff);
				else
					imm = $urandom_range(16'h3000, 16'h3fff);
				return enc_i(st_op[$urandom_range(0, 2)], 5'd0, rt, imm);
			end
			11: begin
				t = $urandom_range(0, CODE_TOP) - (widx + 1);
				return enc_i(br_op[$urandom_range(0, 3)], rs, rt, t[15:0]);
			end
			12: return {($urandom_range(0, 1) ? OP_JAL : OP_J),
				6'd0, 20'($urandom_range(0, CODE_TOP))};
			13: return enc_r(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL);
			default: begin
				if ($urandom_range(0, 1))
					return {bad_op[$urandom_range(0, 4)], 26'($urandom)};
				return enc_r(rs, rt, $urandom, $urandom, bad_fn[$urandom_range(0, 3)]);
			end
		endcase
	endfunction

	// one request, in bursts with random gaps; called at a falling edge
	task automatic send_req(input logic [1:0] c, input logic [11:0] a, input logic [31:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		req_valid <= 1'b1;
		cmd <= c;
		addr <= a;
		data <= d;
		do
			@(posedge clk);
		while (req_stall);
		item_count++;
		@(negedge clk);
	endtask

	task automatic send_read();
		if ($urandom_range(0, 9) == 0)
			send_req(CMD_READ, $urandom_range(34, 4095), $urandom);
		else
			send_req(CMD_READ, $urandom_range(0, 33), $urandom);
	endtask

	// wait for all results, then move pc away from the data area if needed
	task automatic settle_pc(output int w);
		wait (pending == 0);
		@(negedge clk);
		w = cur_pc >> 2;
		if (w > CODE_TOP - 70) begin
			send_req(CMD_LOAD, w, {OP_J, 26'($urandom_range(0, 2000))});
			send_req(CMD_EXEC, $urandom, $urandom);
			wait (pending == 0);
			@(negedge clk);
			w = cur_pc >> 2;
		end
	endtask

	// write the code block at word w and step through it, with random reads and bad commands in between
	task automatic run_code(input int w);
		foreach (code[i])
			send_req(CMD_LOAD, w + i, code[i]);
		foreach (code[i]) begin
			send_req(CMD_EXEC, $urandom, $urandom);
			case ($urandom_range(0, 9))
				0, 1: send_read();
				2: send_req(2'd3, $urandom, $urandom);
				default: ;
			endcase
		end
	endtask

	// receiver stalls in stretches of its own pattern, plus one long hold-off
	initial begin
		int kind, len;
		res_stall <= 1'b0;
		forever begin
			if (hold_now) begin
				hold_now = 1'b0;
				repeat (300) begin
					@(negedge clk);
					res_stall <= 1'b1;
				end
			end
			kind = $urandom_range(0, 2);
			len = $urandom_range(5, 60);
			repeat (len) begin
				@(negedge clk);
				case (kind)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 3) == 0);
					default: res_stall <= $urandom_range(0, 1);
				endcase
			end
		end
	end

	// stimulus and verdict
	initial begin
		logic [31:0] directed[$];
		int          w, n, start_count;
		bit          held;
		arst_n = 1'b0;
		req_valid = 1'b0;
		cmd = CMD_LOAD;
		addr = '0;
		data = '0;
		item_count = 0;
		burst_left = 0;
		hold_now = 1'b0;
		held = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed program: divide edge cases, sign handling, byte lanes, faults, print
		directed = '{
			enc_i(OP_LUI, 5'd0, 5'd8, 16'h8000),
			enc_i(OP_ADDIU, 5'd0, 5'd9, 16'hffff),
			enc_r(5'd8, 5'd9, 5'd0, 5'd0, FN_DIV),
			enc_r(5'd0, 5'd0, 5'd10, 5'd0, FN_MFHI),
			enc_r(5'd0, 5'd0, 5'd11, 5'd0, FN_MFLO),
			enc_r(5'd8, 5'd9, 5'd0, 5'd0, FN_MULT),
			enc_r(5'd0, 5'd8, 5'd12, 5'd31, FN_SRA),
			enc_r(5'd8, 5'd8, 5'd13, 5'd0, FN_ADD),
			enc_r(5'd8, 5'd9, 5'd14, 5'd0, FN_SLT),
			enc_r(5'd8, 5'd9, 5'd15, 5'd0, FN_SLTU),
			enc_i(OP_SW, 5'd0, 5'd8, 16'h3000),
			enc_i(OP_LB, 5'd0, 5'd16, 16'h3003),
			enc_i(OP_LHU, 5'd0, 5'd17, 16'h3002),
			enc_i(OP_LW, 5'd0, 5'd18, 16'h3002),
			enc_i(OP_LW, 5'd0, 5'd18, 16'h7ffc),
			enc_r(5'd8, 5'd0, 5'd0, 5'd0, FN_DIV),
			enc_i(OP_ADDIU, 5'd0, REG_V0, 16'd1),
			enc_i(OP_ADDIU, 5'd0, REG_A0, 16'hfffb),
			enc_r(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL),
			{6'h3f, 26'h3ffffff},
			enc_r(5'd0, 5'd0, 5'd1, 5'd0, 6'h3f),
			enc_i(OP_ADDIU, 5'd0, 5'd0, 16'd5)
		};

		// preload every word so no fetch or load sees unwritten memory
		@(negedge clk);
		for (int i = 0; i < 4096; i++) begin
			if (i < directed.size())
				send_req(CMD_LOAD, i, directed[i]);
			else if (i <= CODE_TOP)
				send_req(CMD_LOAD, i, rand_instr(i));
			else
				send_req(CMD_LOAD, i, $urandom);
		end

		foreach (directed[i])
			send_req(CMD_EXEC, $urandom, $urandom);
		send_req(CMD_READ, 12'd0, 32'd0);
		send_req(CMD_READ, 12'd32, 32'd0);
		send_req(CMD_READ, 12'd33, 32'd0);
		send_req(CMD_READ, 12'hfff, 32'hffffffff);
		send_req(2'd3, 12'd0, 32'd0);

		// random code blocks at the current pc
		start_count = item_count;
		while (item_count - start_count < RANDOM_ITEMS) begin
			settle_pc(w);
			if (!held && item_count - start_count > 600) begin
				hold_now = 1'b1;
				held = 1'b1;
			end
			code.delete();
			n = $urandom_range(1, 12);
			while (code.size() < n) begin
				case ($urandom_range(0, 9))
					0: begin
						code.push_back(enc_i(OP_ADDIU, 5'd0, 5'd8,
							16'($urandom_range(0, CODE_TOP) * 4)));
						code.push_back(enc_r(5'd8, 5'd0, 5'd0, 5'd0, FN_JR));
					end
					1: begin
						code.push_back(enc_i(OP_ADDIU, 5'd0, REG_V0, 16'd1));
						code.push_back(enc_r(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
					end
					default: code.push_back(rand_instr(w + code.size()));
				endcase
			end
			run_code(w);
		end

		// closing: one of halt, misaligned pc or pc beyond memory, each sticks
		settle_pc(w);
		code.delete();
		case ($urandom_range(0, 2))
			0: code = '{enc_i(OP_ADDIU, 5'd0, REG_V0, 16'd10),
				enc_r(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL)};
			1: code = '{enc_i(OP_ADDIU, 5'd0, 5'd8, 16'h0102),
				enc_r(5'd8, 5'd0, 5'd0, 5'd0, FN_JR)};
			default: code = '{enc_i(OP_ADDIU, 5'd0, 5'd8, 16'h7ff0),
				enc_r(5'd8, 5'd0, 5'd0, 5'd0, FN_JR)};
		endcase
		run_code(w);
		repeat (3) send_req(CMD_EXEC, $urandom, $urandom);
		send_req(CMD_READ, 12'd8, 32'd0);
		req_valid <= 1'b0;

		wait (pending == 0);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
